>>> rtl/usm_pkg.sv
`timescale 1ns / 1ps

package usm_pkg;

  // Register map, byte address = 4 * index
  typedef enum logic [1:0] {
    REG_ECHO_TIMEOUT = 2'd0,
    REG_SW_LIMIT     = 2'd1,
    REG_TICKS_PER_CM = 2'd2
  } reg_idx_e;

  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd50000;
  localparam logic [15:0] SW_LIMIT_RST     = 16'd100;
  localparam logic [7:0]  TICKS_PER_CM_RST = 8'd116;

  // Request kinds carried on the input tuser
  typedef enum logic [2:0] {
    FN_ECHO   = 3'd0,
    FN_TENTH  = 3'd1,
    FN_START  = 3'd2,
    FN_STOP   = 3'd3,
    FN_SELECT = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_MEAS1      = 3'd1,
    MODE_MEAS1_DONE = 3'd2,
    MODE_WATCH      = 3'd3,
    MODE_WATCH_DONE = 3'd4,
    MODE_MEAS2      = 3'd5,
    MODE_MEAS2_DONE = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_EXEC,
    CTRL_DIV,
    CTRL_LOAD
  } ctrl_state_e;

  localparam int unsigned DIV_W     = 20;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  localparam int unsigned OUT_DATA_W = 80;

  typedef struct packed {
    logic capture;
    logic step;
    logic div_start;
    logic commit;
    logic load_out;
  } usm_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } usm_status_t;

endpackage

>>> rtl/usm_div.sv
`timescale 1ns / 1ps

// Restoring shift-subtract divider, one quotient bit per cycle
module usm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [usm_pkg::DIV_W-1:0]           dividend_i,
  input  logic [usm_pkg::DIVISOR_W-1:0]       divisor_i,
  output logic                                done_o,
  output logic [usm_pkg::DIV_W-1:0]           quotient_o
);

  logic [usm_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [usm_pkg::DIVISOR_W-1:0] rem_q, rem_d;
  logic [usm_pkg::DIVISOR_W-1:0] dsr_q, dsr_d;
  logic [usm_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [usm_pkg::DIVISOR_W:0]   trial;
  logic [usm_pkg::DIVISOR_W:0]   diff;
  logic                          fits;

  assign trial = {rem_q, quo_q[usm_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[usm_pkg::DIVISOR_W-1:0] : trial[usm_pkg::DIVISOR_W-1:0];
      quo_d = {quo_q[usm_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == usm_pkg::DIV_CNT_W'(usm_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/usm_ctrl.sv
`timescale 1ns / 1ps

module usm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  usm_pkg::usm_status_t status_i,
  output usm_pkg::usm_cmd_t    cmd_o
);

  usm_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= usm_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      usm_pkg::CTRL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = usm_pkg::CTRL_EXEC;
        end
      end
      usm_pkg::CTRL_EXEC: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = usm_pkg::CTRL_DIV;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = usm_pkg::CTRL_LOAD;
        end
      end
      usm_pkg::CTRL_DIV: begin
        if (status_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d      = usm_pkg::CTRL_LOAD;
        end
      end
      usm_pkg::CTRL_LOAD: begin
        // hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = usm_pkg::CTRL_IDLE;
        end
      end
      default: state_d = usm_pkg::CTRL_IDLE;
    endcase
  end

endmodule

>>> rtl/usm_dp.sv
`timescale 1ns / 1ps

module usm_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  usm_pkg::usm_cmd_t                   cmd_i,
  output usm_pkg::usm_status_t                status_o,
  input  logic                                div_done_i,
  input  logic [2:0]                          in_func_i,
  input  logic                                in_level_i,
  input  logic [15:0]                         echo_timeout_i,
  input  logic [15:0]                         sw_limit_i,
  input  logic [7:0]                          ticks_per_cm_i,
  output logic [usm_pkg::DIV_W-1:0]           dividend_o,
  output logic [usm_pkg::DIVISOR_W-1:0]       divisor_o,
  input  logic [usm_pkg::DIV_W-1:0]           quotient_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [usm_pkg::OUT_DATA_W-1:0]      out_data_o
);

  logic [2:0]            func_q;
  logic                  level_q;

  usm_pkg::mode_e        mode_q, mode_d;
  logic                  prev_q, prev_d;
  logic                  counting_q, counting_d;
  logic [15:0]           pulse_q, pulse_d;
  logic [15:0]           d1_q, d1_d;
  logic [15:0]           d2_q, d2_d;
  logic [15:0]           tenths_q, tenths_d;
  logic [20:0]           speed_q, speed_d;
  logic                  remote_q, remote_d;
  logic                  refresh_q, refresh_d;

  logic                  out_valid_q;
  logic [usm_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                  measuring;
  logic                  fall_edge;
  logic                  speed_ok;
  logic                  need_div;
  logic [15:0]           pulse_inc;
  logic [15:0]           tenths_inc;
  logic [16:0]           diff;
  logic [16:0]           diff_mag;
  logic                  diff_neg;
  logic [15:0]           dist_sat;
  logic [20:0]           speed_div;
  logic                  do_settle;

  assign measuring = (mode_q == usm_pkg::MODE_MEAS1) || (mode_q == usm_pkg::MODE_MEAS2);
  assign fall_edge = prev_q && !level_q;
  assign speed_ok  = (d1_q != '0) && (d2_q != '0) && (tenths_q != '0);
  assign need_div  = ((func_q == usm_pkg::FN_ECHO) && measuring && fall_edge) ||
                     ((func_q == usm_pkg::FN_STOP) && speed_ok);

  assign pulse_inc  = (pulse_q == 16'hFFFF) ? pulse_q : pulse_q + 16'd1;
  assign tenths_inc = (tenths_q == 16'hFFFF) ? tenths_q : tenths_q + 16'd1;

  assign diff     = {1'b0, d2_q} - {1'b0, d1_q};
  assign diff_neg = diff[16];
  assign diff_mag = diff_neg ? 17'd0 - diff : diff;

  // times ten as shift and add
  always_comb begin
    if (func_q == usm_pkg::FN_STOP) begin
      dividend_o = ({4'd0, diff_mag[15:0]} << 3) + ({4'd0, diff_mag[15:0]} << 1);
      divisor_o  = tenths_q;
    end else begin
      dividend_o = ({4'd0, pulse_q} << 3) + ({4'd0, pulse_q} << 1);
      divisor_o  = (ticks_per_cm_i == '0) ? 16'd1 : {8'd0, ticks_per_cm_i};
    end
  end

  assign dist_sat  = (quotient_i[19:16] != '0) ? 16'hFFFF : quotient_i[15:0];
  assign speed_div = diff_neg ? 21'd0 - {1'b0, quotient_i} : {1'b0, quotient_i};

  always_comb begin
    mode_d     = mode_q;
    prev_d     = prev_q;
    counting_d = counting_q;
    pulse_d    = pulse_q;
    d1_d       = d1_q;
    d2_d       = d2_q;
    tenths_d   = tenths_q;
    speed_d    = speed_q;
    remote_d   = remote_q;
    refresh_d  = 1'b0;
    do_settle  = 1'b0;
    case (usm_pkg::func_e'(func_q))
      usm_pkg::FN_ECHO: begin
        if (measuring) begin
          if (!prev_q && level_q) begin
            pulse_d    = '0;
            counting_d = 1'b1;
            prev_d     = 1'b1;
          end else if (fall_edge) begin
            counting_d = 1'b0;
            prev_d     = 1'b0;
            if (mode_q == usm_pkg::MODE_MEAS1) begin
              d1_d   = dist_sat;
              mode_d = usm_pkg::MODE_MEAS1_DONE;
            end else begin
              d2_d   = dist_sat;
              mode_d = usm_pkg::MODE_MEAS2_DONE;
            end
          end else if (counting_q) begin
            if (pulse_inc >= echo_timeout_i) begin
              // echo lost: abort, then settle
              counting_d = 1'b0;
              pulse_d    = '0;
              prev_d     = 1'b0;
              speed_d    = '0;
              refresh_d  = 1'b1;
              mode_d     = usm_pkg::MODE_STOP;
              do_settle  = 1'b1;
            end else begin
              pulse_d = pulse_inc;
              prev_d  = level_q;
            end
          end else begin
            prev_d = level_q;
          end
        end
      end
      usm_pkg::FN_TENTH: begin
        if (mode_q == usm_pkg::MODE_WATCH) begin
          if (tenths_inc >= sw_limit_i) begin
            d1_d      = '0;
            d2_d      = '0;
            speed_d   = '0;
            tenths_d  = '0;
            refresh_d = 1'b1;
            mode_d    = usm_pkg::MODE_STOP;
            do_settle = 1'b1;
          end else begin
            tenths_d = tenths_inc;
          end
        end
      end
      usm_pkg::FN_START: begin
        if ((mode_q == usm_pkg::MODE_STOP) || (mode_q == usm_pkg::MODE_MEAS2_DONE)) begin
          tenths_d   = '0;
          d1_d       = '0;
          d2_d       = '0;
          speed_d    = '0;
          pulse_d    = '0;
          counting_d = 1'b0;
          mode_d     = usm_pkg::MODE_MEAS1;
        end
      end
      usm_pkg::FN_STOP: begin
        mode_d    = usm_pkg::MODE_STOP;
        do_settle = 1'b1;
        if (speed_ok) begin
          speed_d = speed_div;
        end
      end
      usm_pkg::FN_SELECT: begin
        remote_d = ~remote_q;
      end
      default: begin
      end
    endcase
    if (do_settle) begin
      if ((d1_d != '0) && (tenths_d == '0)) begin
        mode_d = usm_pkg::MODE_WATCH;
      end else if ((tenths_d != '0) && (d2_d == '0)) begin
        mode_d     = usm_pkg::MODE_MEAS2;
        pulse_d    = '0;
        counting_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_func_i;
      level_q <= in_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= usm_pkg::MODE_STOP;
      prev_q     <= 1'b0;
      counting_q <= 1'b0;
      pulse_q    <= '0;
      d1_q       <= '0;
      d2_q       <= '0;
      tenths_q   <= '0;
      speed_q    <= '0;
      remote_q   <= 1'b0;
      refresh_q  <= 1'b0;
    end else if (cmd_i.step || cmd_i.commit) begin
      mode_q     <= mode_d;
      prev_q     <= prev_d;
      counting_q <= counting_d;
      pulse_q    <= pulse_d;
      d1_q       <= d1_d;
      d2_q       <= d2_d;
      tenths_q   <= tenths_d;
      speed_q    <= speed_d;
      remote_q   <= remote_d;
      refresh_q  <= refresh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= {6'd0, refresh_q, remote_q, speed_q, tenths_q, d2_q, d1_q, mode_q};
    end
  end

  assign status_o.need_div = need_div;
  assign status_o.div_done = div_done_i;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/ultrasonic_two_point_speed_meter_top.sv
`timescale 1ns / 1ps

// Two-point ultrasonic speed meter sequencer. Each request on the input stream
// (echo tick, stopwatch tenth, start, stop, select) yields exactly one status
// word on the output stream. A request is taken when the block is idle; an
// ordinary request is executed and then loaded into the output register once
// it is free, while a falling echo edge in a measure and a stop with both
// distances and a nonzero stopwatch run the shared 20-step shift-subtract
// divider. The output register holds a finished result while the next request
// is taken. Configuration registers sit at byte addresses 0 (echo timeout in
// ticks), 4 (stopwatch limit in tenths) and 8 (echo ticks per centimetre); the
// user must write them only while no request is in flight; nothing enforces it.
module ultrasonic_two_point_speed_meter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [0] echo_level, [7:1] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] func
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] mode, [18:3] first_distance_mm, [34:19] second_distance_mm,
  // [50:35] elapsed_tenths, [71:51] speed_mm_per_s, [72] show_remote,
  // [73] refresh, [79:74] zero
  output logic [79:0] m_axis_tdata_o,
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  logic [15:0] echo_timeout_q;
  logic [15:0] sw_limit_q;
  logic [7:0]  ticks_per_cm_q;
  logic        cfg_wr;

  usm_pkg::usm_cmd_t    cmd;
  usm_pkg::usm_status_t status;
  logic                 div_done;
  logic [usm_pkg::DIV_W-1:0]     dividend;
  logic [usm_pkg::DIVISOR_W-1:0] divisor;
  logic [usm_pkg::DIV_W-1:0]     quotient;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_timeout_q <= usm_pkg::ECHO_TIMEOUT_RST;
      sw_limit_q     <= usm_pkg::SW_LIMIT_RST;
      ticks_per_cm_q <= usm_pkg::TICKS_PER_CM_RST;
    end else if (cfg_wr) begin
      case (usm_pkg::reg_idx_e'(paddr_i[3:2]))
        usm_pkg::REG_ECHO_TIMEOUT: echo_timeout_q <= pwdata_i[15:0];
        usm_pkg::REG_SW_LIMIT:     sw_limit_q     <= pwdata_i[15:0];
        usm_pkg::REG_TICKS_PER_CM: ticks_per_cm_q <= pwdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (usm_pkg::reg_idx_e'(paddr_i[3:2]))
      usm_pkg::REG_ECHO_TIMEOUT: prdata_o = {16'd0, echo_timeout_q};
      usm_pkg::REG_SW_LIMIT:     prdata_o = {16'd0, sw_limit_q};
      usm_pkg::REG_TICKS_PER_CM: prdata_o = {24'd0, ticks_per_cm_q};
      default:                   prdata_o = '0;
    endcase
  end

  usm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  usm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .div_done_i     (div_done),
    .in_func_i      (s_axis_tuser_i),
    .in_level_i     (s_axis_tdata_i[0]),
    .echo_timeout_i (echo_timeout_q),
    .sw_limit_i     (sw_limit_q),
    .ticks_per_cm_i (ticks_per_cm_q),
    .dividend_o     (dividend),
    .divisor_o      (divisor),
    .quotient_i     (quotient),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_data_o     (m_axis_tdata_o)
  );

  usm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

endmodule

>>> rtl/usm_checker.sv
`timescale 1ns / 1ps

module usm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [79:0] m_axis_tdata_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in flight");

  // a forced stop ends in stop or a retried second measure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[73] |->
      (m_axis_tdata_o[2:0] == usm_pkg::MODE_STOP) ||
      (m_axis_tdata_o[2:0] == usm_pkg::MODE_MEAS2))
    else $error("refresh with unexpected mode");

  // modes that are never entered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] != usm_pkg::MODE_WATCH_DONE) &&
                        (m_axis_tdata_o[2:0] <= usm_pkg::MODE_MEAS2_DONE))
    else $error("illegal mode reported");

  // the first measure always starts from a cleared run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == usm_pkg::MODE_MEAS1) |->
      (m_axis_tdata_o[18:3] == 16'd0) && (m_axis_tdata_o[34:19] == 16'd0) &&
      (m_axis_tdata_o[50:35] == 16'd0) && (m_axis_tdata_o[71:51] == 21'd0))
    else $error("first measure with stale run data");

endmodule

bind ultrasonic_two_point_speed_meter_top usm_checker u_usm_checker (.*);

>>> test/usm_status_monitor.sv
`timescale 1ns / 1ps

module usm_status_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [0] echo_level, [7:1] zero
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] func
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [2:0] mode, [18:3] first_distance_mm, [34:19] second_distance_mm,
  // [50:35] elapsed_tenths, [71:51] speed_mm_per_s, [72] show_remote,
  // [73] refresh, [79:74] zero
  input  logic [79:0] m_axis_tdata_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // Same layout as the output tdata, lowest field last
  typedef struct packed {
    logic           refresh;
    logic           show_remote;
    logic [20:0]    speed;
    logic [15:0]    tenths;
    logic [15:0]    dist2;
    logic [15:0]    dist1;
    usm_pkg::mode_e mode;
  } status_t;

  logic [15:0] cfg_timeout;
  logic [15:0] cfg_limit;
  logic [7:0]  cfg_tpc;

  usm_pkg::mode_e mode_q;
  logic        echo_prev;
  logic        pulse_on;
  logic [15:0] pulse_cnt;
  logic [15:0] d1;
  logic [15:0] d2;
  logic [15:0] tenths;
  logic [20:0] speed;
  logic        remote;

  status_t     status_due_q[$];
  int unsigned mismatches;

  function automatic logic [15:0] ticks_to_mm(input logic [15:0] ticks);
    logic [31:0] mm;
    mm = (32'(ticks) * 32'd10) / ((cfg_tpc == 8'd0) ? 32'd1 : 32'(cfg_tpc));
    return (mm > 32'd65535) ? 16'hFFFF : mm[15:0];
  endfunction

  // From stop, move on to the stopwatch or retry the second measure
  function automatic void settle_after_stop();
    if (mode_q != usm_pkg::MODE_STOP) return;
    if (d1 != 16'd0 && tenths == 16'd0) begin
      mode_q = usm_pkg::MODE_WATCH;
    end else if (tenths != 16'd0 && d2 == 16'd0) begin
      mode_q    = usm_pkg::MODE_MEAS2;
      pulse_cnt = 16'd0;
      pulse_on  = 1'b0;
    end
  endfunction

  function automatic logic take_echo(input logic lvl);
    if (mode_q != usm_pkg::MODE_MEAS1 && mode_q != usm_pkg::MODE_MEAS2) return 1'b0;
    if (!echo_prev && lvl) begin
      pulse_cnt = 16'd0;
      pulse_on  = 1'b1;
    end else if (echo_prev && !lvl) begin
      pulse_on = 1'b0;
      if (mode_q == usm_pkg::MODE_MEAS1) begin
        d1     = ticks_to_mm(pulse_cnt);
        mode_q = usm_pkg::MODE_MEAS1_DONE;
      end else begin
        d2     = ticks_to_mm(pulse_cnt);
        mode_q = usm_pkg::MODE_MEAS2_DONE;
      end
    end else if (pulse_on) begin
      if (pulse_cnt != 16'hFFFF) pulse_cnt++;
      if (pulse_cnt >= cfg_timeout) begin
        pulse_on  = 1'b0;
        pulse_cnt = 16'd0;
        echo_prev = 1'b0;
        speed     = '0;
        mode_q    = usm_pkg::MODE_STOP;
        settle_after_stop();
        return 1'b1;
      end
    end
    echo_prev = lvl;
    return 1'b0;
  endfunction

  function automatic void take_stop();
    int diff;
    int mag;
    int quot;
    mode_q = usm_pkg::MODE_STOP;
    if (d1 != 16'd0 && d2 != 16'd0 && tenths != 16'd0) begin
      diff  = int'(d2) - int'(d1);
      mag   = (diff < 0) ? -diff : diff;
      quot  = (mag * 10) / int'(tenths);
      if (diff < 0) quot = -quot;
      speed = quot[20:0];
    end
    settle_after_stop();
  endfunction

  function automatic status_t next_status(input logic [2:0] fn, input logic lvl);
    status_t st;
    logic    rf;
    rf = 1'b0;
    case (fn)
      usm_pkg::FN_ECHO: begin
        rf = take_echo(lvl);
      end
      usm_pkg::FN_TENTH: begin
        if (mode_q == usm_pkg::MODE_WATCH) begin
          if (tenths != 16'hFFFF) tenths++;
          if (tenths >= cfg_limit) begin
            d1     = 16'd0;
            d2     = 16'd0;
            speed  = '0;
            tenths = 16'd0;
            rf     = 1'b1;
            mode_q = usm_pkg::MODE_STOP;
            settle_after_stop();
          end
        end
      end
      usm_pkg::FN_START: begin
        if (mode_q == usm_pkg::MODE_STOP || mode_q == usm_pkg::MODE_MEAS2_DONE) begin
          tenths    = 16'd0;
          d1        = 16'd0;
          d2        = 16'd0;
          speed     = '0;
          pulse_cnt = 16'd0;
          pulse_on  = 1'b0;
          mode_q    = usm_pkg::MODE_MEAS1;
        end
      end
      usm_pkg::FN_STOP: begin
        take_stop();
      end
      usm_pkg::FN_SELECT: begin
        remote = ~remote;
      end
      default: ;
    endcase
    st.mode        = mode_q;
    st.dist1       = d1;
    st.dist2       = d2;
    st.tenths      = tenths;
    st.speed       = speed;
    st.show_remote = remote;
    st.refresh     = rf;
    return st;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    status_t seen;
    status_t due;
    if (!rst_ni) begin
      cfg_timeout  = usm_pkg::ECHO_TIMEOUT_RST;
      cfg_limit    = usm_pkg::SW_LIMIT_RST;
      cfg_tpc      = usm_pkg::TICKS_PER_CM_RST;
      mode_q       = usm_pkg::MODE_STOP;
      echo_prev    = 1'b0;
      pulse_on     = 1'b0;
      pulse_cnt    = 16'd0;
      d1           = 16'd0;
      d2           = 16'd0;
      tenths       = 16'd0;
      speed        = '0;
      remote       = 1'b0;
      mismatches   = 0;
      status_due_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Check the older result first: a request taken at this edge cannot answer yet
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen = status_t'(m_axis_tdata_i[73:0]);
        if (status_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status word %h with no request outstanding",
                     $realtime, m_axis_tdata_i);
        end else begin
          due = status_due_q.pop_front();
          if (seen.mode !== due.mode || seen.dist1 !== due.dist1 ||
              seen.dist2 !== due.dist2 || seen.tenths !== due.tenths ||
              seen.speed !== due.speed || seen.show_remote !== due.show_remote ||
              seen.refresh !== due.refresh) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: status mismatch, expected mode %0d d1 %0d d2 %0d tenths %0d",
                        " speed %0d remote %0b refresh %0b, got mode %0d d1 %0d d2 %0d",
                        " tenths %0d speed %0d remote %0b refresh %0b"},
                       $realtime, due.mode, due.dist1, due.dist2, due.tenths,
                       $signed(due.speed), due.show_remote, due.refresh,
                       seen.mode, seen.dist1, seen.dist2, seen.tenths,
                       $signed(seen.speed), seen.show_remote, seen.refresh);
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (usm_pkg::reg_idx_e'(paddr_i[3:2]))
          usm_pkg::REG_ECHO_TIMEOUT: cfg_timeout = pwdata_i[15:0];
          usm_pkg::REG_SW_LIMIT:     cfg_limit   = pwdata_i[15:0];
          usm_pkg::REG_TICKS_PER_CM: cfg_tpc     = pwdata_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        status_due_q.push_back(next_status(s_axis_tuser_i, s_axis_tdata_i[0]));
      fail_count_o <= mismatches;
      pending_o    <= status_due_q.size();
    end
  end

endmodule

>>> test/tb_ultrasonic_two_point_speed_meter_top.sv
`timescale 1ns / 1ps

module tb_ultrasonic_two_point_speed_meter_top;

  localparam logic [2:0]  FN_SPARE         = 3'd5;
  localparam int unsigned RANDOM_REQS      = 1800;
  localparam int unsigned QUIET_TAIL       = 250;
  localparam int unsigned HOLD_AT          = 300;
  localparam int unsigned HOLD_CYCLES      = 600;
  localparam int unsigned SETTLE_CYCLES    = 30;
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic [2:0]  s_tuser  = usm_pkg::FN_ECHO;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned reqs_sent   = 0;
  int unsigned quiet_from  = 32'hFFFF_FFFF;
  int unsigned cycle_count = 0;
  int unsigned pulse_max   = 120;
  int unsigned tenth_max   = 30;
  bit          quiet       = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ultrasonic_two_point_speed_meter_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  usm_status_monitor i_status_monitor (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Offer one request; tvalid stays high after the handshake unless the caller drops it
  task automatic send_req(input logic [2:0] fn, input logic lvl);
    quiet = (reqs_sent >= quiet_from);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {7'd0, lvl};
    do @(posedge clk); while (!s_tready);
    reqs_sent++;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 9) == 0)
      send_req(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  // Low lead-in, rising edge, width counted high ticks, falling edge
  task automatic send_pulse(input int unsigned lead, input int unsigned width);
    repeat (lead) send_req(usm_pkg::FN_ECHO, 1'b0);
    send_req(usm_pkg::FN_ECHO, 1'b1);
    repeat (width) begin
      send_noise();
      send_req(usm_pkg::FN_ECHO, 1'b1);
    end
    send_req(usm_pkg::FN_ECHO, 1'b0);
  endtask

  task automatic measure_run(input int unsigned first_width);
    send_noise();
    send_req(usm_pkg::FN_START, 1'($urandom_range(0, 1)));
    send_pulse($urandom_range(0, 3), first_width);
    send_noise();
    send_req(usm_pkg::FN_STOP, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, tenth_max)) begin
      send_noise();
      send_req(usm_pkg::FN_TENTH, 1'($urandom_range(0, 1)));
    end
    send_req(usm_pkg::FN_STOP, 1'($urandom_range(0, 1)));
    send_pulse($urandom_range(0, 3), $urandom_range(0, pulse_max));
    send_noise();
    send_req(usm_pkg::FN_STOP, 1'($urandom_range(0, 1)));
  endtask

  // Drop tvalid, wait for every status word, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input usm_pkg::reg_idx_e idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_config(input logic [15:0] timeout, input logic [15:0] limit,
                            input logic [7:0] tpc);
    drain();
    apb_write(usm_pkg::REG_ECHO_TIMEOUT, timeout);
    apb_write(usm_pkg::REG_SW_LIMIT, limit);
    apb_write(usm_pkg::REG_TICKS_PER_CM, 16'(tpc));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && reqs_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: selects, spare codes, requests out of place
    send_req(usm_pkg::FN_SELECT, 1'b1);
    send_req(usm_pkg::FN_SELECT, 1'b0);
    send_req(FN_SPARE, 1'b1);
    send_req(FN_SPARE + 3'd1, 1'b0);
    send_req(FN_SPARE + 3'd2, 1'b1);
    send_req(usm_pkg::FN_ECHO, 1'b1);
    send_req(usm_pkg::FN_TENTH, 1'b0);
    send_req(usm_pkg::FN_STOP, 1'b1);
    send_req(usm_pkg::FN_START, 1'b0);
    send_req(usm_pkg::FN_ECHO, 1'b1);
    send_req(usm_pkg::FN_ECHO, 1'b0);
    send_req(usm_pkg::FN_START, 1'b1);
    send_req(usm_pkg::FN_STOP, 1'b0);
    send_req(usm_pkg::FN_START, 1'b0);
    send_req(usm_pkg::FN_ECHO, 1'b1);
    // Echo still high across stop and start: the next low is a falling edge with no count
    send_req(usm_pkg::FN_STOP, 1'b0);
    send_req(usm_pkg::FN_START, 1'b1);
    send_req(usm_pkg::FN_ECHO, 1'b0);
    send_req(usm_pkg::FN_TENTH, 1'b1);
    send_req(usm_pkg::FN_STOP, 1'b1);

    goal       = reqs_sent + RANDOM_REQS;
    quiet_from = goal - QUIET_TAIL;
    for (int p = 0; reqs_sent < goal; p++) begin
      case (p)
        0: begin
          set_config(16'd30, 16'd12, usm_pkg::TICKS_PER_CM_RST);
          pulse_max = 45;
          tenth_max = 16;
        end
        1: begin
          set_config(16'd1, 16'd1, 8'd255);
          pulse_max = 3;
          tenth_max = 3;
        end
        2: begin
          set_config(16'hFFFF, 16'hFFFF, 8'd1);
          pulse_max = 200;
          tenth_max = 40;
        end
        3: begin
          set_config(usm_pkg::ECHO_TIMEOUT_RST, usm_pkg::SW_LIMIT_RST,
                     usm_pkg::TICKS_PER_CM_RST);
          pulse_max = 120;
          tenth_max = 30;
        end
        default: begin
          set_config(16'($urandom_range(1, 200)), 16'($urandom_range(1, 40)),
                     8'($urandom_range(1, 255)));
          pulse_max = $urandom_range(5, 210);
          tenth_max = $urandom_range(1, 44);
        end
      endcase
      repeat (4) measure_run($urandom_range(0, pulse_max));
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
